>>> design/tfbs_pkg.sv
package tfbs_pkg;

  // Buffer ownership marks.
  typedef logic [1:0] mark_t;
  localparam mark_t MarkFree     = 2'd0;
  localparam mark_t MarkClaimed  = 2'd1;
  localparam mark_t MarkComplete = 2'd2;

  // Buffer slot number.
  typedef logic [1:0] slot_t;

  // Register file layout.
  localparam int unsigned PaddrW = 5;
  typedef logic [2:0] reg_idx_t;
  localparam reg_idx_t RegBuffer0Base   = 3'd0;
  localparam reg_idx_t RegBuffer1Base   = 3'd1;
  localparam reg_idx_t RegBuffer2Base   = 3'd2;
  localparam reg_idx_t RegFrameBytes    = 3'd3;
  localparam reg_idx_t RegLineBytes     = 3'd4;
  localparam reg_idx_t RegLinesPerFrame = 3'd5;
  localparam reg_idx_t RegLevelWord     = 3'd6;
  localparam reg_idx_t RegGapTicks      = 3'd7;

  // Reset values of the registers.
  localparam logic [31:0] Buffer0BaseRst   = 32'h0000_0000;
  localparam logic [31:0] Buffer1BaseRst   = 32'h0200_0000;
  localparam logic [31:0] Buffer2BaseRst   = 32'h0400_0000;
  localparam logic [23:0] FrameBytesRst    = 24'd655360;
  localparam logic [15:0] LineBytesRst     = 16'd1280;
  localparam logic [9:0]  LinesPerFrameRst = 10'd512;
  localparam logic [15:0] LevelWordRst     = 16'd320;
  localparam logic [7:0]  GapTicksRst      = 8'd1;

  // Configuration as seen by the sequencer core.
  typedef struct packed {
    logic [31:0] buffer0_base;
    logic [31:0] buffer1_base;
    logic [31:0] buffer2_base;
    logic [23:0] frame_bytes;
    logic [15:0] line_bytes;
    logic [9:0]  lines_per_frame;
    logic [15:0] level_word;
    logic [7:0]  gap_ticks;
  } cfg_t;

  // One service tick.
  typedef struct packed {
    logic active;
    logic capture_done;
    logic send_done;
  } in_item_t;

  // One tick result.
  typedef struct packed {
    logic        capture_start;
    logic        capture_stop;
    logic [31:0] capture_base;
    logic [23:0] capture_length;
    logic        send_start;
    logic        send_stop;
    logic [31:0] send_base;
    logic [15:0] send_length;
    logic [9:0]  send_line;
    logic [15:0] send_level;
    logic [31:0] frames_sent;
  } out_item_t;

endpackage

>>> design/tfbs_regs.sv
module tfbs_regs
  import tfbs_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  cfg_t     cfg_q;
  reg_idx_t idx;
  logic     wr_en;

  assign idx    = paddr[PaddrW-1:2];
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  // Register writes on the access cycle of a write transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.buffer0_base    <= Buffer0BaseRst;
      cfg_q.buffer1_base    <= Buffer1BaseRst;
      cfg_q.buffer2_base    <= Buffer2BaseRst;
      cfg_q.frame_bytes     <= FrameBytesRst;
      cfg_q.line_bytes      <= LineBytesRst;
      cfg_q.lines_per_frame <= LinesPerFrameRst;
      cfg_q.level_word      <= LevelWordRst;
      cfg_q.gap_ticks       <= GapTicksRst;
    end else if (wr_en) begin
      unique case (idx)
        RegBuffer0Base:   cfg_q.buffer0_base    <= pwdata;
        RegBuffer1Base:   cfg_q.buffer1_base    <= pwdata;
        RegBuffer2Base:   cfg_q.buffer2_base    <= pwdata;
        RegFrameBytes:    cfg_q.frame_bytes     <= pwdata[23:0];
        RegLineBytes:     cfg_q.line_bytes      <= pwdata[15:0];
        RegLinesPerFrame: cfg_q.lines_per_frame <= pwdata[9:0];
        RegLevelWord:     cfg_q.level_word      <= pwdata[15:0];
        RegGapTicks:      cfg_q.gap_ticks       <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Read data mux.
  always_comb begin
    unique case (idx)
      RegBuffer0Base:   prdata = cfg_q.buffer0_base;
      RegBuffer1Base:   prdata = cfg_q.buffer1_base;
      RegBuffer2Base:   prdata = cfg_q.buffer2_base;
      RegFrameBytes:    prdata = 32'(cfg_q.frame_bytes);
      RegLineBytes:     prdata = 32'(cfg_q.line_bytes);
      RegLinesPerFrame: prdata = 32'(cfg_q.lines_per_frame);
      RegLevelWord:     prdata = 32'(cfg_q.level_word);
      RegGapTicks:      prdata = 32'(cfg_q.gap_ticks);
      default:          prdata = '0;
    endcase
  end

endmodule

>>> design/tfbs_core.sv
module tfbs_core
  import tfbs_pkg::*;
#(
  parameter int unsigned NUM_BUFFERS = 3
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  logic      step_i,
  input  in_item_t  item_i,
  output out_item_t result_o
);

  // Sequencer state.
  logic [NUM_BUFFERS-1:0][1:0] marks_q, marks_mid, marks_d;
  logic        cap_busy_q, cap_busy_d;
  slot_t       cap_slot_q, cap_slot_d;
  logic        sending_q, sending_d;
  logic        snd_busy_q, snd_busy_d;
  slot_t       snd_slot_q, snd_slot_d;
  logic [9:0]  line_q, line_d;
  logic [7:0]  gap_q, gap_d;
  logic [31:0] frame_q, frame_d;

  // Buffer selection.
  logic        empty_hit, unclaimed_hit, free_hit, cmp_hit;
  slot_t       empty_slot, unclaimed_slot, free_slot, cmp_slot;
  logic [9:0]  line_inc;
  logic [25:0] line_offset;
  logic [31:0] cap_base, snd_base;

  // Capture side fields of the result.
  out_item_t   cap_res;

  // Lowest free buffer: one with no frame first, else a complete unclaimed one.
  always_comb begin
    empty_hit      = 1'b0;
    empty_slot     = '0;
    unclaimed_hit  = 1'b0;
    unclaimed_slot = '0;
    for (int k = NUM_BUFFERS - 1; k >= 0; k--) begin
      if (marks_q[k] == MarkFree) begin
        empty_hit  = 1'b1;
        empty_slot = slot_t'(k);
      end
      if ((marks_q[k] & MarkClaimed) == MarkFree) begin
        unclaimed_hit  = 1'b1;
        unclaimed_slot = slot_t'(k);
      end
    end
    free_hit  = empty_hit | unclaimed_hit;
    free_slot = empty_hit ? empty_slot : unclaimed_slot;
  end

  // Lowest complete buffer, seen after the capture step of this tick.
  always_comb begin
    cmp_hit  = 1'b0;
    cmp_slot = '0;
    for (int k = NUM_BUFFERS - 1; k >= 0; k--) begin
      if ((marks_mid[k] & MarkComplete) != MarkFree) begin
        cmp_hit  = 1'b1;
        cmp_slot = slot_t'(k);
      end
    end
  end

  // Buffer base lookup and line address.
  assign cap_base    = (free_slot == 2'd0) ? cfg_i.buffer0_base :
                       (free_slot == 2'd1) ? cfg_i.buffer1_base : cfg_i.buffer2_base;
  assign snd_base    = (snd_slot_q == 2'd0) ? cfg_i.buffer0_base :
                       (snd_slot_q == 2'd1) ? cfg_i.buffer1_base : cfg_i.buffer2_base;
  assign line_offset = line_q * cfg_i.line_bytes;
  assign line_inc    = line_q + 10'd1;

  // Capture step.
  always_comb begin
    marks_mid  = marks_q;
    cap_busy_d = cap_busy_q;
    cap_slot_d = cap_slot_q;
    cap_res    = '0;
    if (item_i.active) begin
      if (cap_busy_q) begin
        if (item_i.capture_done) begin
          cap_busy_d           = 1'b0;
          cap_res.capture_stop = 1'b1;
          for (int k = 0; k < NUM_BUFFERS; k++) begin
            if (cap_slot_q == slot_t'(k)) marks_mid[k] = MarkComplete;
          end
        end
      end else if (free_hit) begin
        cap_slot_d             = free_slot;
        cap_busy_d             = 1'b1;
        cap_res.capture_start  = 1'b1;
        cap_res.capture_base   = cap_base;
        cap_res.capture_length = cfg_i.frame_bytes;
        for (int k = 0; k < NUM_BUFFERS; k++) begin
          if (free_slot == slot_t'(k)) marks_mid[k] = MarkClaimed;
        end
      end
    end
  end

  // Transmit step.
  always_comb begin
    marks_d    = marks_mid;
    sending_d  = sending_q;
    snd_busy_d = snd_busy_q;
    snd_slot_d = snd_slot_q;
    line_d     = line_q;
    gap_d      = gap_q;
    frame_d    = frame_q;
    result_o   = cap_res;
    result_o.send_start  = 1'b0;
    result_o.send_stop   = 1'b0;
    result_o.send_base   = '0;
    result_o.send_length = '0;
    result_o.send_line   = '0;
    result_o.send_level  = '0;
    if (item_i.active) begin
      if (!sending_q) begin
        if (cmp_hit) begin
          frame_d            = frame_q + 32'd1;
          sending_d          = 1'b1;
          snd_slot_d         = cmp_slot;
          line_d             = '0;
          snd_busy_d         = 1'b0;
          result_o.send_stop = 1'b1;
          for (int k = 0; k < NUM_BUFFERS; k++) begin
            if (cmp_slot == slot_t'(k)) marks_d[k] = MarkClaimed;
          end
        end
      end else if (snd_busy_q) begin
        if (item_i.send_done) begin
          snd_busy_d         = 1'b0;
          result_o.send_stop = 1'b1;
          gap_d              = cfg_i.gap_ticks;
          line_d             = line_inc;
          // Last line of the frame releases the buffer.
          if (line_inc == cfg_i.lines_per_frame) begin
            sending_d = 1'b0;
            for (int k = 0; k < NUM_BUFFERS; k++) begin
              if (snd_slot_q == slot_t'(k)) marks_d[k] = MarkFree;
            end
          end
        end
      end else if (gap_q != 8'd0) begin
        gap_d = gap_q - 8'd1;
      end else begin
        snd_busy_d           = 1'b1;
        result_o.send_start  = 1'b1;
        result_o.send_base   = snd_base + {6'd0, line_offset};
        result_o.send_length = cfg_i.line_bytes;
        result_o.send_line   = line_q;
        result_o.send_level  = cfg_i.level_word;
      end
    end
    result_o.frames_sent = frame_d;
  end

  // State update once per processed tick.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      marks_q    <= '0;
      cap_busy_q <= 1'b0;
      cap_slot_q <= '0;
      sending_q  <= 1'b0;
      snd_busy_q <= 1'b0;
      snd_slot_q <= '0;
      line_q     <= '0;
      gap_q      <= '0;
      frame_q    <= '0;
    end else if (step_i) begin
      marks_q    <= marks_d;
      cap_busy_q <= cap_busy_d;
      cap_slot_q <= cap_slot_d;
      sending_q  <= sending_d;
      snd_busy_q <= snd_busy_d;
      snd_slot_q <= snd_slot_d;
      line_q     <= line_d;
      gap_q      <= gap_d;
      frame_q    <= frame_d;
    end
  end

endmodule

>>> design/triple_frame_buffer_sequencer.sv
// Triple frame buffer sequencer: hands frame buffers between a capture engine
// and a line transmit engine. Each transfer on the input channel is one
// service tick and yields exactly one result transfer. A tick is taken every
// clock cycle while in_stall_o is low; it waits in the input register, its
// result goes into the result register and transfers when out_stall_i is low,
// with the buffer choice and line address (base plus line times line length)
// computed in the single pass between the two registers. The input register
// lets a new tick enter while the previous result is still stalled. Registers
// sit on an APB port at byte offsets 0x00 to 0x1C and should be written only
// while no tick is in flight.
module triple_frame_buffer_sequencer
  import tfbs_pkg::*;
#(
  parameter int unsigned NUM_BUFFERS = 3
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  in_item_t          in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output out_item_t         out_data_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  cfg_t      cfg;
  logic      in_valid_q;
  in_item_t  in_item_q;
  logic      out_valid_q;
  out_item_t out_item_q;
  out_item_t result;
  logic      advance;

  // Register file.
  tfbs_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Tick processing and ownership state.
  tfbs_core #(
    .NUM_BUFFERS (NUM_BUFFERS)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .step_i   (advance),
    .item_i   (in_item_q),
    .result_o (result)
  );

  // The held tick moves on when the result register is empty or draining.
  assign advance     = in_valid_q & (~out_valid_q | ~out_stall_i);
  assign in_stall_o  = in_valid_q & ~advance;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_item_q;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_valid_i && !in_stall_o) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_item_q <= in_data_i;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_item_q <= result;
    end
  end

endmodule
